/* sv/motor_drive_output_supervisor_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the drive supervisor's arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DRIVE_OUTPUT_SUPERVISOR_ASSERT_SVH
`define MOTOR_DRIVE_OUTPUT_SUPERVISOR_ASSERT_SVH

// same-cycle implication
`define MDOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mdos assertion failed");

// next-cycle implication
`define MDOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mdos assertion failed");

`endif

/* sv/mdos_pkg.sv */
// ----------------------------------------------------------------------------
// mdos_pkg
// Types, codes and constants of the motor drive output supervisor.
// ----------------------------------------------------------------------------
package mdos_pkg;

  localparam logic [1:0] FUNC_CMD  = 2'd0;
  localparam logic [1:0] FUNC_FB   = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] REG_CURRENT_LIMIT   = 3'd0;
  localparam logic [2:0] REG_BUS_MOTOR       = 3'd1;
  localparam logic [2:0] REG_OVERTEMP_ENABLE = 3'd2;
  localparam logic [2:0] REG_CRITICAL_TEMP   = 3'd3;
  localparam logic [2:0] REG_CUTOFF_TEMP     = 3'd4;
  localparam logic [2:0] REG_MOTOR_ENABLE    = 3'd5;
  localparam logic [2:0] REG_LOST_LIMIT      = 3'd6;
  localparam logic [2:0] REG_STALE_LIMIT     = 3'd7;

  localparam logic [14:0] RST_CURRENT_LIMIT = 15'd16384;
  localparam logic [8:0]  RST_CRITICAL_TEMP = 9'd175;
  localparam logic [8:0]  RST_CUTOFF_TEMP   = 9'd200;
  localparam logic [7:0]  RST_LOST_LIMIT    = 8'd5;
  localparam logic [7:0]  RST_STALE_LIMIT   = 8'd100;

  localparam logic [15:0] SCALE_ONE = 16'd32768;
  localparam logic [7:0]  CNT_MAX   = 8'd255;
  localparam int          DIV_STEPS = 24;

  typedef struct packed {
    logic [14:0] current_limit;
    logic        bus_motor;
    logic        overtemp_enable;
    logic [8:0]  critical_temp;
    logic [8:0]  cutoff_temp;
    logic        motor_enable;
    logic [7:0]  lost_limit;
    logic [7:0]  stale_limit;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] mag;
    logic [15:0] scale;
    logic [8:0]  kn;
    logic [8:0]  kd;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } arith_rsp_t;

  typedef struct packed {
    logic               fire;
    logic [1:0]         func;
    logic signed [15:0] applied;
    logic               send;
    logic               deforce;
  } commit_t;

  typedef struct packed {
    logic signed [15:0] applied;
    logic signed [15:0] drive_value;
    logic               lost;
    logic               stale;
  } wd_status_t;

endpackage

/* sv/mdos_ifs.sv */
// ----------------------------------------------------------------------------
// mdos_in_if / mdos_out_if
// Valid/ready channels carrying drive items and drive results.
// ----------------------------------------------------------------------------
interface mdos_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] current;
  logic signed [8:0]  temperature;
  logic [15:0]        power_scale;
  logic               send_flag;
  logic               deforce;

  modport source (output valid, func, current, temperature, power_scale, send_flag, deforce,
                  input ready);
  modport sink (input valid, func, current, temperature, power_scale, send_flag, deforce,
                output ready);
endinterface

interface mdos_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] applied_current;
  logic signed [15:0] drive_value;
  logic               lost;
  logic               stale;

  modport source (output valid, applied_current, drive_value, lost, stale, input ready);
  modport sink (input valid, applied_current, drive_value, lost, stale, output ready);
endinterface

/* sv/motor_drive_output_supervisor.sv */
// ----------------------------------------------------------------------------
// motor_drive_output_supervisor
// One motor channel's drive stage: clamp, thermal derating, power scaling,
// gating into the drive buffer, loss and refresh watchdogs.
//
//   port     | dir | handshake            | word
//   ---------+-----+----------------------+-----------------------------------
//   in_ch    | in  | valid / ready        | func, current, temperature, ...
//   out_ch   | out | valid / ready        | applied_current, drive_value, ...
//   p*       | i/o | APB, pready always 1 | 8 registers at byte address 4*i
//
// A command word's result goes through two passes of the shared multiplier,
// 24 steps of the restoring divider, the capture of the quotient, the commit
// and the output register. Feedback and tick words skip the arithmetic and
// go straight to the commit. One word is in flight at a time.
// A result waiting on out_ch holds the block after its work is done.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module motor_drive_output_supervisor (
  input  logic              clk,
  input  logic              rst_n,
  mdos_in_if.sink           in_ch,
  mdos_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mdos_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  cfg_t       cfg;
  arith_req_t areq;
  arith_rsp_t arsp;
  commit_t    cmt;
  wd_status_t wst;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         func_r;
  logic               send_r;
  logic               deforce_r;
  logic               neg_r;
  logic signed [15:0] value_r;
  logic               out_valid_r;
  logic signed [15:0] out_applied_r;
  logic signed [15:0] out_drive_r;
  logic               out_lost_r;
  logic               out_stale_r;

  logic               accept;
  logic               commit;
  logic signed [15:0] lim;
  logic signed [15:0] nlim;
  logic signed [15:0] cclamp;
  logic [15:0]        mag;
  logic signed [11:0] t2;
  logic signed [11:0] cut12;
  logic signed [11:0] crit12;
  logic signed [11:0] kn12;
  logic [8:0]         kd;
  logic [8:0]         kn;
  logic [15:0]        scale;

  mdos_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // clamp
  assign lim  = signed'({1'b0, cfg.current_limit});
  assign nlim = -lim;
  always_comb begin
    cclamp = in_ch.current;
    if (cfg.bus_motor) begin
      if (in_ch.current > lim) begin
        cclamp = lim;
      end else if (in_ch.current < nlim) begin
        cclamp = nlim;
      end
    end
  end
  assign mag = cclamp[15] ? 16'(-cclamp) : cclamp;

  // derating factor kn / kd
  assign t2     = {{2{in_ch.temperature[8]}}, in_ch.temperature, 1'b0};
  assign cut12  = signed'({3'd0, cfg.cutoff_temp});
  assign crit12 = signed'({3'd0, cfg.critical_temp});
  assign kn12   = cut12 - t2;
  always_comb begin
    kn = 9'd1;
    kd = 9'd1;
    if (cfg.overtemp_enable) begin
      if (cfg.cutoff_temp > cfg.critical_temp) begin
        kd = cfg.cutoff_temp - cfg.critical_temp;
        if (kn12 < 12'sd0) begin
          kn = 9'd0;
        end else if (kn12 > signed'({3'd0, kd})) begin
          kn = kd;
        end else begin
          kn = kn12[8:0];
        end
      end else begin
        kn = (t2 < crit12) ? 9'd1 : 9'd0;
      end
    end
  end

  assign scale = (in_ch.power_scale > SCALE_ONE) ? SCALE_ONE : in_ch.power_scale;

  assign areq.start = accept && (in_ch.func == FUNC_CMD);
  assign areq.mag   = mag;
  assign areq.scale = scale;
  assign areq.kn    = kn;
  assign areq.kd    = kd;

  mdos_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign cmt.fire    = commit;
  assign cmt.func    = func_r;
  assign cmt.applied = value_r;
  assign cmt.send    = send_r;
  assign cmt.deforce = deforce_r;

  mdos_wdog u_wdog (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmt        (cmt),
    .status_nxt (wst)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.func == FUNC_CMD) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (arsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_ch.func;
      send_r    <= in_ch.send_flag;
      deforce_r <= in_ch.deforce;
      neg_r     <= cclamp[15];
    end
    if (state_r == ST_RUN && arsp.done) begin
      value_r <= neg_r ? 16'(-arsp.quot) : arsp.quot;
    end
    if (commit) begin
      out_applied_r <= wst.applied;
      out_drive_r   <= wst.drive_value;
      out_lost_r    <= wst.lost;
      out_stale_r   <= wst.stale;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.applied_current = out_applied_r;
  assign out_ch.drive_value     = out_drive_r;
  assign out_ch.lost            = out_lost_r;
  assign out_ch.stale           = out_stale_r;

endmodule

/* sv/mdos_regs.sv */
// ----------------------------------------------------------------------------
// mdos_regs
// APB-style configuration register file, one register per word address.
// ----------------------------------------------------------------------------
module mdos_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output mdos_pkg::cfg_t   cfg
);
  import mdos_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limit   <= RST_CURRENT_LIMIT;
      cfg_r.bus_motor       <= 1'b1;
      cfg_r.overtemp_enable <= 1'b1;
      cfg_r.critical_temp   <= RST_CRITICAL_TEMP;
      cfg_r.cutoff_temp     <= RST_CUTOFF_TEMP;
      cfg_r.motor_enable    <= 1'b1;
      cfg_r.lost_limit      <= RST_LOST_LIMIT;
      cfg_r.stale_limit     <= RST_STALE_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_CURRENT_LIMIT:   cfg_r.current_limit   <= pwdata[14:0];
        REG_BUS_MOTOR:       cfg_r.bus_motor       <= pwdata[0];
        REG_OVERTEMP_ENABLE: cfg_r.overtemp_enable <= pwdata[0];
        REG_CRITICAL_TEMP:   cfg_r.critical_temp   <= pwdata[8:0];
        REG_CUTOFF_TEMP:     cfg_r.cutoff_temp     <= pwdata[8:0];
        REG_MOTOR_ENABLE:    cfg_r.motor_enable    <= pwdata[0];
        REG_LOST_LIMIT:      cfg_r.lost_limit      <= pwdata[7:0];
        REG_STALE_LIMIT:     cfg_r.stale_limit     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CURRENT_LIMIT:   prdata = {17'd0, cfg_r.current_limit};
      REG_BUS_MOTOR:       prdata = {31'd0, cfg_r.bus_motor};
      REG_OVERTEMP_ENABLE: prdata = {31'd0, cfg_r.overtemp_enable};
      REG_CRITICAL_TEMP:   prdata = {23'd0, cfg_r.critical_temp};
      REG_CUTOFF_TEMP:     prdata = {23'd0, cfg_r.cutoff_temp};
      REG_MOTOR_ENABLE:    prdata = {31'd0, cfg_r.motor_enable};
      REG_LOST_LIMIT:      prdata = {24'd0, cfg_r.lost_limit};
      REG_STALE_LIMIT:     prdata = {24'd0, cfg_r.stale_limit};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

/* sv/mdos_arith.sv */
// ----------------------------------------------------------------------------
// mdos_arith
// Shared multiply / restoring-divide unit: (mag * scale * kn >> 15) / kd.
// ----------------------------------------------------------------------------
module mdos_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdos_pkg::arith_req_t req,
  output mdos_pkg::arith_rsp_t rsp
);
  import mdos_pkg::*;

  `include "motor_drive_output_supervisor_assert.svh"

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL1 = 3'd1;
  localparam logic [2:0] PH_MUL2 = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [15:0] scale_r;
  logic [8:0]  kn_r;
  logic [8:0]  kd_r;

  logic [15:0] mul_b;
  logic [46:0] mul_full;
  logic [9:0]  rem_sh;
  logic [9:0]  rem_diff;
  logic        ge;

  assign mul_b    = (phase_r == PH_MUL1) ? scale_r : {7'd0, kn_r};
  assign mul_full = {16'd0, acc_r} * {31'd0, mul_b};
  assign rem_sh   = {rem_r, acc_r[23]};
  assign ge       = rem_sh >= {1'b0, kd_r};
  assign rem_diff = rem_sh - {1'b0, kd_r};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          acc_nxt   = {15'd0, req.mag};
          phase_nxt = PH_MUL1;
        end
      end
      PH_MUL1: begin
        acc_nxt   = mul_full[30:0];
        phase_nxt = PH_MUL2;
      end
      PH_MUL2: begin
        acc_nxt   = {7'd0, mul_full[38:15]};
        rem_nxt   = 9'd0;
        cnt_nxt   = 5'd0;
        phase_nxt = PH_DIV;
      end
      PH_DIV: begin
        acc_nxt = {7'd0, acc_r[22:0], ge};
        rem_nxt = ge ? rem_diff[8:0] : rem_sh[8:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          phase_nxt = PH_FIN;
        end
      end
      PH_FIN: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (phase_r == PH_IDLE && req.start) begin
      scale_r <= req.scale;
      kn_r    <= req.kn;
      kd_r    <= req.kd;
    end
  end

  assign rsp.done = (phase_r == PH_FIN);
  assign rsp.quot = acc_r[15:0];

  `MDOS_ASSERT_IMPL(a_start_idle, clk, rst_n, req.start, phase_r == PH_IDLE)
  `MDOS_ASSERT_IMPL(a_quot_fits, clk, rst_n, rsp.done, acc_r[23:16] == 8'd0)
  `MDOS_ASSERT_IMPL(a_rem_below, clk, rst_n, phase_r == PH_DIV, rem_r < kd_r)
  `MDOS_ASSERT_NEXT(a_div_len, clk, rst_n, phase_r == PH_MUL2,
                    phase_r == PH_DIV && cnt_r == 5'd0)

endmodule

/* sv/mdos_wdog.sv */
// ----------------------------------------------------------------------------
// mdos_wdog
// Drive buffer, loss and refresh watchdogs; gating of the command result.
// ----------------------------------------------------------------------------
module mdos_wdog (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdos_pkg::cfg_t       cfg,
  input  mdos_pkg::commit_t    cmt,
  output mdos_pkg::wd_status_t status_nxt
);
  import mdos_pkg::*;

  logic signed [15:0] drive_r, drive_nxt;
  logic [7:0]         lost_cnt_r, lost_cnt_nxt;
  logic               lost_r, lost_nxt;
  logic [7:0]         refresh_cnt_r, refresh_cnt_nxt;
  logic               stale_r, stale_nxt;
  logic signed [15:0] applied;
  logic               active;

  assign active = cfg.motor_enable && cfg.bus_motor;

  always_comb begin
    drive_nxt       = drive_r;
    lost_cnt_nxt    = lost_cnt_r;
    lost_nxt        = lost_r;
    refresh_cnt_nxt = refresh_cnt_r;
    stale_nxt       = stale_r;
    applied         = 16'sd0;
    case (cmt.func)
      FUNC_CMD: begin
        applied = cmt.applied;
        if (cmt.send && active) begin
          if (lost_r || cmt.deforce) begin
            applied = 16'sd0;
          end
          drive_nxt       = applied;
          refresh_cnt_nxt = 8'd0;
          stale_nxt       = 1'b0;
        end
      end
      FUNC_FB: begin
        lost_cnt_nxt = 8'd0;
        lost_nxt     = 1'b0;
      end
      FUNC_TICK: begin
        if (active) begin
          if (lost_cnt_r > cfg.lost_limit) begin
            lost_nxt  = 1'b1;
            drive_nxt = 16'sd0;
          end else begin
            if (lost_cnt_r < CNT_MAX) begin
              lost_cnt_nxt = lost_cnt_r + 8'd1;
            end
            if (refresh_cnt_r > cfg.stale_limit) begin
              stale_nxt = 1'b1;
              drive_nxt = 16'sd0;
            end else if (cmt.deforce) begin
              drive_nxt = 16'sd0;
            end else if (refresh_cnt_r < CNT_MAX) begin
              refresh_cnt_nxt = refresh_cnt_r + 8'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r       <= 16'sd0;
      lost_cnt_r    <= 8'd0;
      lost_r        <= 1'b1;
      refresh_cnt_r <= 8'd0;
      stale_r       <= 1'b0;
    end else if (cmt.fire) begin
      drive_r       <= drive_nxt;
      lost_cnt_r    <= lost_cnt_nxt;
      lost_r        <= lost_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      stale_r       <= stale_nxt;
    end
  end

  assign status_nxt.applied     = applied;
  assign status_nxt.drive_value = drive_nxt;
  assign status_nxt.lost        = lost_nxt;
  assign status_nxt.stale       = stale_nxt;

endmodule
